// ===== sv/rsi_pkg.sv =====
// Shared types and constants for the ray-sphere intersection block.
package rsi_pkg;

    localparam int NUM_AXES    = 3;
    localparam int SQ_STEPS    = 67;
    localparam int DIV_STEPS   = 32;
    localparam int NRM_STEPS   = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_RADIUS
    } cfg_index_t;

    typedef logic signed [31:0] fx_t;
    typedef logic signed [17:0] nrm_t;

    typedef struct packed {
        fx_t [NUM_AXES-1:0] origin;
        fx_t [NUM_AXES-1:0] dir;
        fx_t                t_min;
        fx_t                t_max;
    } ray_t;

    typedef struct packed {
        fx_t [NUM_AXES-1:0] center;
        logic [30:0]        radius;
    } sphere_t;

    typedef struct packed {
        ray_t               ray;
        logic signed [66:0] h;
        logic [63:0]        a;
        logic [133:0]       disc;
        logic               miss;
    } fe_item_t;

    typedef struct packed {
        logic                hit;
        fx_t                 hit_t;
        fx_t [NUM_AXES-1:0]  point;
        nrm_t [NUM_AXES-1:0] normal;
    } result_t;

endpackage

// ===== sv/rsi_mul.sv =====
// Three-stage pipelined 68 by 68 bit signed multiplier built from 24-bit partial products.
module rsi_mul (
    input  logic                clk,
    input  logic                en,
    input  logic signed [67:0]  a,
    input  logic signed [67:0]  b,
    output logic signed [135:0] prod
);
    logic signed [23:0]  a_chunk [3];
    logic signed [23:0]  b_chunk [3];
    logic signed [47:0]  pp_reg [3][3];
    logic signed [135:0] row_next [3];
    logic signed [135:0] row_reg [3];
    logic signed [135:0] prod_reg;

    always_comb
    begin
        a_chunk[0] = {1'b0, a[22:0]};
        a_chunk[1] = {1'b0, a[45:23]};
        a_chunk[2] = {{2{a[67]}}, a[67:46]};
        b_chunk[0] = {1'b0, b[22:0]};
        b_chunk[1] = {1'b0, b[45:23]};
        b_chunk[2] = {{2{b[67]}}, b[67:46]};
        for (int i = 0; i < 3; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < 3; j++)
            begin
                row_next[i] = row_next[i]
                    + ($signed({{88{pp_reg[i][j][47]}}, pp_reg[i][j]}) <<< (23 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pp_reg[i][j] <= a_chunk[i] * b_chunk[j];
                end
                row_reg[i] <= row_next[i];
            end
            prod_reg <= row_reg[0] + row_reg[1] + row_reg[2];
        end
    end

    assign prod = prod_reg;

endmodule

// ===== sv/rsi_front.sv =====
// Front part: accepts rays and forms the quadratic and its discriminant, marking early misses.
module rsi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rsi_pkg::ray_t     in_ray,
    input  rsi_pkg::sphere_t  sphere,
    output logic              out_valid,
    output rsi_pkg::fe_item_t out_item,
    input  logic              out_full
);
    import rsi_pkg::*;

    logic               adv;

    logic               v1_reg;
    ray_t               ray1_reg;
    logic signed [32:0] oc1_reg [NUM_AXES];
    logic signed [32:0] oc_next [NUM_AXES];

    logic               v2_reg;
    ray_t               ray2_reg;
    logic [62:0]        dd2_reg [NUM_AXES];
    logic signed [64:0] doc2_reg [NUM_AXES];
    logic [65:0]        mm2_reg [NUM_AXES];
    logic [61:0]        rr2_reg;
    logic signed [63:0] dd_next [NUM_AXES];
    logic signed [64:0] doc_next [NUM_AXES];
    logic [32:0]        mag_next [NUM_AXES];
    logic [65:0]        mm_next [NUM_AXES];

    logic               v3_reg;
    ray_t               ray3_reg;
    logic [63:0]        a3_reg;
    logic signed [66:0] h3_reg;
    logic signed [66:0] c3_reg;
    logic [63:0]        a_next;
    logic signed [66:0] h_next;
    logic signed [66:0] c_next;

    logic               dl_v_reg [3];
    ray_t               dl_ray_reg [3];
    logic signed [66:0] dl_h_reg [3];
    logic [63:0]        dl_a_reg [3];

    logic signed [135:0] hh;
    logic signed [135:0] ac;
    logic signed [135:0] disc_next;
    fe_item_t            item_next;

    logic                v7_reg;
    fe_item_t            item7_reg;

    assign adv      = !v7_reg || !out_full;
    assign in_ready = adv;

    rsi_mul u_mul_hh (
        .clk  (clk),
        .en   (adv),
        .a    (68'(h3_reg)),
        .b    (68'(h3_reg)),
        .prod (hh)
    );

    rsi_mul u_mul_ac (
        .clk  (clk),
        .en   (adv),
        .a    ($signed({4'b0000, a3_reg})),
        .b    (68'(c3_reg)),
        .prod (ac)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            oc_next[i]  = 33'(in_ray.origin[i]) - 33'(sphere.center[i]);
            dd_next[i]  = 64'(ray1_reg.dir[i]) * 64'(ray1_reg.dir[i]);
            doc_next[i] = 65'(ray1_reg.dir[i]) * 65'(oc1_reg[i]);
            mag_next[i] = oc1_reg[i][32] ? 33'(-oc1_reg[i]) : 33'(oc1_reg[i]);
            mm_next[i]  = 66'(mag_next[i]) * 66'(mag_next[i]);
        end
        a_next = 64'(dd2_reg[0]) + 64'(dd2_reg[1]) + 64'(dd2_reg[2]);
        h_next = 67'(doc2_reg[0]) + 67'(doc2_reg[1]) + 67'(doc2_reg[2]);
        c_next = 67'(mm2_reg[0]) + 67'(mm2_reg[1]) + 67'(mm2_reg[2]) - 67'(rr2_reg);

        disc_next      = hh - ac;
        item_next.ray  = dl_ray_reg[2];
        item_next.h    = dl_h_reg[2];
        item_next.a    = dl_a_reg[2];
        item_next.miss = (dl_a_reg[2] == 64'd0) || disc_next[135];
        item_next.disc = item_next.miss ? '0 : disc_next[133:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                dl_v_reg[k] <= 1'b0;
            end
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            dl_v_reg[0] <= v3_reg;
            dl_v_reg[1] <= dl_v_reg[0];
            dl_v_reg[2] <= dl_v_reg[1];
            v7_reg      <= dl_v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ray1_reg <= in_ray;
            ray2_reg <= ray1_reg;
            ray3_reg <= ray2_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                oc1_reg[i]  <= oc_next[i];
                dd2_reg[i]  <= dd_next[i][62:0];
                doc2_reg[i] <= doc_next[i];
                mm2_reg[i]  <= mm_next[i];
            end
            rr2_reg <= 62'(sphere.radius) * 62'(sphere.radius);
            a3_reg  <= a_next;
            h3_reg  <= h_next;
            c3_reg  <= c_next;
            dl_ray_reg[0] <= ray3_reg;
            dl_h_reg[0]   <= h3_reg;
            dl_a_reg[0]   <= a3_reg;
            for (int k = 1; k < 3; k++)
            begin
                dl_ray_reg[k] <= dl_ray_reg[k-1];
                dl_h_reg[k]   <= dl_h_reg[k-1];
                dl_a_reg[k]   <= dl_a_reg[k-1];
            end
            item7_reg <= item_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_item  = item7_reg;

endmodule

// ===== sv/rsi_queue.sv =====
// Short register queue that decouples the front part from the back part.
module rsi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_req,
    input  rsi_pkg::fe_item_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output rsi_pkg::fe_item_t pop_data
);
    import rsi_pkg::*;

    fe_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push_ok;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign push_ok = push_req && !full;

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue popped while empty");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != QCNT_W'(QUEUE_DEPTH)) |->
            (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0]))
        else $error("queue pointers disagree with count");

endmodule

// ===== sv/rsi_back.sv =====
// Back part: square root, root division, interval test, hit point and normal.
module rsi_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rsi_pkg::sphere_t  sphere,
    input  logic              in_valid,
    input  rsi_pkg::fe_item_t in_item,
    output logic              in_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output rsi_pkg::result_t  out_result
);
    import rsi_pkg::*;

    typedef struct packed {
        ray_t               ray;
        logic signed [66:0] h;
        logic [63:0]        a;
        logic               miss;
    } sq_pay_t;

    typedef struct packed {
        ray_t        ray;
        logic [63:0] a;
        logic        miss;
    } dv_pay_t;

    typedef struct packed {
        ray_t ray;
        fx_t  t;
        logic miss;
    } pt_pay_t;

    typedef struct packed {
        fx_t                t;
        fx_t [NUM_AXES-1:0] point;
        logic [NUM_AXES-1:0] neg;
        logic [NUM_AXES-1:0] big;
        logic               miss;
    } nd_pay_t;

    logic adv;

    logic         sq_v_reg [SQ_STEPS+1];
    sq_pay_t      sq_pay_reg [SQ_STEPS+1];
    logic [68:0]  sq_rem_reg [SQ_STEPS+1];
    logic [66:0]  sq_root_reg [SQ_STEPS+1];
    logic [133:0] sq_dsh_reg [SQ_STEPS+1];
    logic [68:0]  sq_rem_next [SQ_STEPS];
    logic [66:0]  sq_root_next [SQ_STEPS];

    logic               ns_v_reg;
    dv_pay_t            ns_pay_reg;
    logic signed [84:0] ns_x_reg;
    logic signed [64:0] ns_pml_reg;
    logic signed [64:0] ns_pmh_reg;
    logic signed [65:0] ns_pxl_reg;
    logic signed [65:0] ns_pxh_reg;
    logic signed [68:0] n_val;
    logic signed [32:0] t_top;
    logic signed [32:0] a_lo_s;
    logic signed [32:0] a_hi_s;

    logic               l_v_reg;
    dv_pay_t            l_pay_reg;
    logic signed [84:0] l_x_reg;
    logic signed [98:0] l_lo_reg;
    logic signed [98:0] l_hi_reg;
    logic signed [98:0] x_wide;
    logic signed [98:0] r_wide;

    logic        dv_v_reg [DIV_STEPS+1];
    dv_pay_t     dv_pay_reg [DIV_STEPS+1];
    logic [63:0] dv_rem_reg [DIV_STEPS+1];
    logic [31:0] dv_low_reg [DIV_STEPS+1];
    logic [31:0] dv_q_reg [DIV_STEPS+1];
    logic [63:0] dv_rem_next [DIV_STEPS];
    logic [31:0] dv_q_next [DIV_STEPS];

    logic               t_v_reg;
    pt_pay_t            t_pay_reg;
    logic signed [32:0] t_sum;

    logic               p_v_reg;
    pt_pay_t            p_pay_reg;
    logic signed [63:0] p_prod_reg [NUM_AXES];

    logic               nd_v_reg [NRM_STEPS+1];
    nd_pay_t            nd_pay_reg [NRM_STEPS+1];
    logic [30:0]        nd_rem_reg [NRM_STEPS+1][NUM_AXES];
    logic [16:0]        nd_low_reg [NRM_STEPS+1][NUM_AXES];
    logic [16:0]        nd_q_reg [NRM_STEPS+1][NUM_AXES];
    logic [30:0]        nd_rem_next [NRM_STEPS][NUM_AXES];
    logic [16:0]        nd_q_next [NRM_STEPS][NUM_AXES];
    nd_pay_t            nd0_pay;
    logic signed [49:0] pos [NUM_AXES];
    logic signed [49:0] rel [NUM_AXES];
    logic [49:0]        mag [NUM_AXES];

    logic    out_v_reg;
    result_t res_reg;
    result_t res_next;
    logic [17:0] nmag [NUM_AXES];

    assign adv    = !out_v_reg || out_ready;
    assign in_pop = in_valid && adv;

    always_comb
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if ({sq_rem_reg[k], sq_dsh_reg[k][133:132]} >= {2'b00, sq_root_reg[k], 2'b01})
            begin
                sq_rem_next[k]  = 69'({sq_rem_reg[k], sq_dsh_reg[k][133:132]}
                                      - {2'b00, sq_root_reg[k], 2'b01});
                sq_root_next[k] = {sq_root_reg[k][65:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = 69'({sq_rem_reg[k], sq_dsh_reg[k][133:132]});
                sq_root_next[k] = {sq_root_reg[k][65:0], 1'b0};
            end
        end

        n_val  = -69'(sq_pay_reg[SQ_STEPS].h) - $signed({2'b00, sq_root_reg[SQ_STEPS]});
        t_top  = 33'(sq_pay_reg[SQ_STEPS].ray.t_max) + 33'sd1;
        a_lo_s = $signed({1'b0, sq_pay_reg[SQ_STEPS].a[31:0]});
        a_hi_s = $signed({1'b0, sq_pay_reg[SQ_STEPS].a[63:32]});

        x_wide = 99'(l_x_reg);
        r_wide = x_wide - l_lo_reg;

        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if ({dv_rem_reg[k], dv_low_reg[k][31]} >= {1'b0, dv_pay_reg[k].a})
            begin
                dv_rem_next[k] = 64'({dv_rem_reg[k], dv_low_reg[k][31]}
                                     - {1'b0, dv_pay_reg[k].a});
                dv_q_next[k]   = {dv_q_reg[k][30:0], 1'b1};
            end
            else
            begin
                dv_rem_next[k] = 64'({dv_rem_reg[k], dv_low_reg[k][31]});
                dv_q_next[k]   = {dv_q_reg[k][30:0], 1'b0};
            end
        end

        t_sum = 33'(dv_pay_reg[DIV_STEPS].ray.t_min) + $signed({1'b0, dv_q_reg[DIV_STEPS]});

        nd0_pay.t    = p_pay_reg.t;
        nd0_pay.miss = p_pay_reg.miss;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            pos[i] = 50'(p_pay_reg.ray.origin[i]) + 50'(p_prod_reg[i] >>> 16);
            rel[i] = pos[i] - 50'(sphere.center[i]);
            mag[i] = rel[i][49] ? 50'(-rel[i]) : 50'(rel[i]);
            if (pos[i] > 50'sd2147483647)
            begin
                nd0_pay.point[i] = 32'sh7fffffff;
            end
            else if (pos[i] < -50'sd2147483648)
            begin
                nd0_pay.point[i] = 32'sh80000000;
            end
            else
            begin
                nd0_pay.point[i] = 32'(pos[i]);
            end
            nd0_pay.neg[i] = rel[i][49];
            nd0_pay.big[i] = (mag[i] >= 50'({sphere.radius, 1'b0}));
        end

        for (int k = 0; k < NRM_STEPS; k++)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if ({nd_rem_reg[k][i], nd_low_reg[k][i][16]} >= {1'b0, sphere.radius})
                begin
                    nd_rem_next[k][i] = 31'({nd_rem_reg[k][i], nd_low_reg[k][i][16]}
                                            - {1'b0, sphere.radius});
                    nd_q_next[k][i]   = {nd_q_reg[k][i][15:0], 1'b1};
                end
                else
                begin
                    nd_rem_next[k][i] = 31'({nd_rem_reg[k][i], nd_low_reg[k][i][16]});
                    nd_q_next[k][i]   = {nd_q_reg[k][i][15:0], 1'b0};
                end
            end
        end

        res_next.hit   = !nd_pay_reg[NRM_STEPS].miss;
        res_next.hit_t = nd_pay_reg[NRM_STEPS].miss ? '0 : nd_pay_reg[NRM_STEPS].t;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            res_next.point[i] = nd_pay_reg[NRM_STEPS].miss ? '0
                                                           : nd_pay_reg[NRM_STEPS].point[i];
            nmag[i] = 18'(nd_q_reg[NRM_STEPS][i])
                      + 18'(nd_rem_reg[NRM_STEPS][i] != '0);
            if (nd_pay_reg[NRM_STEPS].miss || (sphere.radius == '0))
            begin
                res_next.normal[i] = '0;
            end
            else if (nd_pay_reg[NRM_STEPS].neg[i])
            begin
                if (nd_pay_reg[NRM_STEPS].big[i] || (nmag[i] > 18'd65536))
                begin
                    res_next.normal[i] = -18'sd65536;
                end
                else
                begin
                    res_next.normal[i] = -$signed(nmag[i]);
                end
            end
            else
            begin
                if (nd_pay_reg[NRM_STEPS].big[i]
                    || (nd_q_reg[NRM_STEPS][i] > 17'd65536))
                begin
                    res_next.normal[i] = 18'sd65536;
                end
                else
                begin
                    res_next.normal[i] = $signed({1'b0, nd_q_reg[NRM_STEPS][i]});
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            ns_v_reg <= 1'b0;
            l_v_reg  <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            t_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            for (int k = 0; k <= NRM_STEPS; k++)
            begin
                nd_v_reg[k] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= in_valid;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            ns_v_reg    <= sq_v_reg[SQ_STEPS];
            l_v_reg     <= ns_v_reg;
            dv_v_reg[0] <= l_v_reg;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
            t_v_reg     <= dv_v_reg[DIV_STEPS];
            p_v_reg     <= t_v_reg;
            nd_v_reg[0] <= p_v_reg;
            for (int k = 0; k < NRM_STEPS; k++)
            begin
                nd_v_reg[k+1] <= nd_v_reg[k];
            end
            out_v_reg <= nd_v_reg[NRM_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_pay_reg[0].ray  <= in_item.ray;
            sq_pay_reg[0].h    <= in_item.h;
            sq_pay_reg[0].a    <= in_item.a;
            sq_pay_reg[0].miss <= in_item.miss;
            sq_rem_reg[0]      <= '0;
            sq_root_reg[0]     <= '0;
            sq_dsh_reg[0]      <= in_item.disc;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_pay_reg[k+1]  <= sq_pay_reg[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_dsh_reg[k+1]  <= {sq_dsh_reg[k][131:0], 2'b00};
            end

            ns_pay_reg.ray  <= sq_pay_reg[SQ_STEPS].ray;
            ns_pay_reg.a    <= sq_pay_reg[SQ_STEPS].a;
            ns_pay_reg.miss <= sq_pay_reg[SQ_STEPS].miss;
            ns_x_reg   <= $signed({n_val, 16'h0000});
            ns_pml_reg <= 65'(sq_pay_reg[SQ_STEPS].ray.t_min) * 65'(a_lo_s);
            ns_pmh_reg <= 65'(sq_pay_reg[SQ_STEPS].ray.t_min) * 65'(a_hi_s);
            ns_pxl_reg <= 66'(t_top) * 66'(a_lo_s);
            ns_pxh_reg <= 66'(t_top) * 66'(a_hi_s);

            l_pay_reg <= ns_pay_reg;
            l_x_reg   <= ns_x_reg;
            l_lo_reg  <= (99'(ns_pmh_reg) <<< 32) + 99'(ns_pml_reg);
            l_hi_reg  <= (99'(ns_pxh_reg) <<< 32) + 99'(ns_pxl_reg);

            dv_pay_reg[0].ray  <= l_pay_reg.ray;
            dv_pay_reg[0].a    <= l_pay_reg.a;
            dv_pay_reg[0].miss <= l_pay_reg.miss || (x_wide < l_lo_reg)
                                  || (x_wide >= l_hi_reg);
            dv_rem_reg[0] <= r_wide[95:32];
            dv_low_reg[0] <= r_wide[31:0];
            dv_q_reg[0]   <= '0;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_pay_reg[k+1] <= dv_pay_reg[k];
                dv_rem_reg[k+1] <= dv_rem_next[k];
                dv_low_reg[k+1] <= {dv_low_reg[k][30:0], 1'b0};
                dv_q_reg[k+1]   <= dv_q_next[k];
            end

            t_pay_reg.ray  <= dv_pay_reg[DIV_STEPS].ray;
            t_pay_reg.t    <= 32'(t_sum);
            t_pay_reg.miss <= dv_pay_reg[DIV_STEPS].miss;

            p_pay_reg <= t_pay_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                p_prod_reg[i] <= 64'(t_pay_reg.ray.dir[i]) * 64'(t_pay_reg.t);
            end

            nd_pay_reg[0] <= nd0_pay;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                nd_rem_reg[0][i] <= mag[i][31:1];
                nd_low_reg[0][i] <= {mag[i][0], 16'h0000};
                nd_q_reg[0][i]   <= '0;
            end
            for (int k = 0; k < NRM_STEPS; k++)
            begin
                nd_pay_reg[k+1] <= nd_pay_reg[k];
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    nd_rem_reg[k+1][i] <= nd_rem_next[k][i];
                    nd_low_reg[k+1][i] <= {nd_low_reg[k][i][15:0], 1'b0};
                    nd_q_reg[k+1][i]   <= nd_q_next[k][i];
                end
            end

            res_reg <= res_next;
        end
    end

    assign out_valid  = out_v_reg;
    assign out_result = res_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !res_reg.hit) |->
            (res_reg.hit_t == '0 && res_reg.point == '0 && res_reg.normal == '0))
        else $error("miss item carries nonzero fields");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (t_v_reg && !t_pay_reg.miss) |->
            ($signed(t_pay_reg.t) >= $signed(t_pay_reg.ray.t_min)
             && $signed(t_pay_reg.t) <= $signed(t_pay_reg.ray.t_max)))
        else $error("hit parameter outside the interval");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(res_reg) && $stable(sq_root_reg[SQ_STEPS]))
        else $error("back pipeline moved while stalled");

endmodule

// ===== sv/ray_sphere_intersect_top.sv =====
// Top level of the ray-sphere intersection block: configuration registers and stream ports.
//
// Rays enter on the s_ stream at one item per clock while s_tready is high and leave on
// the m_ stream in order, one result item per ray. The datapath is fully pipelined: the
// front part forms the quadratic and discriminant, a 4-entry queue separates it from the
// back part, and the back part holds a 67-stage square root, a 32-stage root division
// and 17-stage normal divisions. Throughput is one item per clock while m_tready is high.
// Sphere center and radius are written on the cfg_ port and must only change while no item
// is in flight.
module ray_sphere_intersect_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max (32 bits each)
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit(1), hit_t(32), point_x/y/z(32 each), normal_x/y/z(18 each), one zero pad bit
    output logic [183:0] m_tdata
);
    import rsi_pkg::*;

    sphere_t  sphere_reg;
    ray_t     in_ray;
    fe_item_t fe_item;
    fe_item_t q_item;
    result_t  result;
    logic     fe_valid;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere_reg.center <= '0;
            sphere_reg.radius <= 31'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_CENTER_X: sphere_reg.center[0] <= cfg_data;
                CFG_CENTER_Y: sphere_reg.center[1] <= cfg_data;
                CFG_CENTER_Z: sphere_reg.center[2] <= cfg_data;
                CFG_RADIUS:   sphere_reg.radius    <= cfg_data[30:0];
                default:      sphere_reg           <= sphere_reg;
            endcase
        end
    end

    always_comb
    begin
        in_ray.origin[0] = s_tdata[31:0];
        in_ray.origin[1] = s_tdata[63:32];
        in_ray.origin[2] = s_tdata[95:64];
        in_ray.dir[0]    = s_tdata[127:96];
        in_ray.dir[1]    = s_tdata[159:128];
        in_ray.dir[2]    = s_tdata[191:160];
        in_ray.t_min     = s_tdata[223:192];
        in_ray.t_max     = s_tdata[255:224];
    end

    rsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_ray    (in_ray),
        .sphere    (sphere_reg),
        .out_valid (fe_valid),
        .out_item  (fe_item),
        .out_full  (q_full)
    );

    rsi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_req  (fe_valid),
        .push_data (fe_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_item)
    );

    rsi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .sphere     (sphere_reg),
        .in_valid   (q_valid),
        .in_item    (q_item),
        .in_pop     (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {1'b0,
                      result.normal[2], result.normal[1], result.normal[0],
                      result.point[2], result.point[1], result.point[0],
                      result.hit_t, result.hit};

endmodule
